### src/cvs_pkg.sv
// cvs_pkg: shared constants, types and register codes of the class vote stabilizer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package cvs_pkg;

	// Block sizing
	localparam int MAX_CLASSES  = 16;
	localparam int COUNTER_BITS = 8;

	// Fixed field widths
	localparam int CFG_W  = 8;
	localparam int CIU_W  = 5;
	localparam int MEAS_W = 6;
	localparam int SC_W   = 4;
	localparam int REG_W  = 2;

	// Derived widths
	localparam int IDX_W   = $clog2(MAX_CLASSES);
	localparam int WALK_W  = $clog2(MAX_CLASSES + 1);
	localparam int N_W     = (WALK_W > CIU_W) ? WALK_W : CIU_W;
	localparam int CMP_W   = (IDX_W > MEAS_W) ? IDX_W : MEAS_W;
	localparam int ARITH_W = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;

	localparam logic [ARITH_W-1:0] CNT_TOP = ARITH_W'((1 << COUNTER_BITS) - 1);

	// Configuration register reset values
	localparam logic [CIU_W-1:0] CIU_RST   = CIU_W'(16);
	localparam logic [CFG_W-1:0] FLOOR_RST = CFG_W'(0);
	localparam logic [CFG_W-1:0] CEIL_RST  = CFG_W'(20);
	localparam logic [CFG_W-1:0] THR_RST   = CFG_W'(10);

	typedef enum logic [REG_W-1:0] {
		REG_CLASSES_IN_USE,
		REG_COUNT_FLOOR,
		REG_COUNT_CEILING,
		REG_VOTE_THRESHOLD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Result of one counter visit from the update unit
	typedef struct packed {
		logic [COUNTER_BITS-1:0] new_val;
		logic                    active;
		logic                    take_best;
	} step_res_t;

endpackage
`default_nettype wire

### src/cvs_if.sv
// cvs_if: request channels of the class vote stabilizer (input decisions, output results).
// Depends on cvs_pkg for field widths.
`default_nettype none
interface cvs_in_if;
	logic                          valid;
	logic                          ready;
	logic [cvs_pkg::MEAS_W-1:0]    measured_class;

	modport source (output valid, output measured_class, input ready);
	modport sink   (input valid, input measured_class, output ready);
endinterface

interface cvs_out_if;
	logic                          valid;
	logic                          ready;
	logic                          stable_valid;
	logic [cvs_pkg::SC_W-1:0]      stable_class;
	logic                          active_flag;

	modport source (output valid, output stable_valid, output stable_class,
		output active_flag, input ready);
	modport sink   (input valid, input stable_valid, input stable_class,
		input active_flag, output ready);
endinterface
`default_nettype wire

### src/cvs_update_unit.sv
// cvs_update_unit: shared saturating count, activity and argmax step for one class counter.
// Depends on cvs_pkg; used once per cycle by the top level while walking the classes.
`default_nettype none
module cvs_update_unit (
	input  wire logic [cvs_pkg::COUNTER_BITS-1:0] cnt,
	input  wire logic                             match,
	input  wire logic [cvs_pkg::CFG_W-1:0]        floor_val,
	input  wire logic [cvs_pkg::CFG_W-1:0]        ceil_val,
	input  wire logic [cvs_pkg::CFG_W-1:0]        thr_val,
	input  wire logic                             act,
	input  wire logic                             have,
	input  wire logic [cvs_pkg::COUNTER_BITS-1:0] best_val,
	output cvs_pkg::step_res_t                    res
);

	logic [cvs_pkg::ARITH_W-1:0] c_w;
	logic [cvs_pkg::ARITH_W-1:0] floor_w;
	logic [cvs_pkg::ARITH_W-1:0] ceil_w;
	logic [cvs_pkg::ARITH_W-1:0] thr_w;
	logic [cvs_pkg::ARITH_W-1:0] up_w;
	logic [cvs_pkg::ARITH_W-1:0] dn_w;
	logic [cvs_pkg::ARITH_W-1:0] nv_w;
	logic [cvs_pkg::ARITH_W-1:0] sat_w;
	logic [cvs_pkg::COUNTER_BITS-1:0] nv;

	assign c_w     = cvs_pkg::ARITH_W'(cnt);
	assign floor_w = cvs_pkg::ARITH_W'(floor_val);
	assign ceil_w  = cvs_pkg::ARITH_W'(ceil_val);
	assign thr_w   = cvs_pkg::ARITH_W'(thr_val);

	// Count up toward the ceiling, down toward the floor
	always_comb begin
		up_w = c_w + cvs_pkg::ARITH_W'(1);
		if (up_w > ceil_w) begin
			up_w = ceil_w;
		end
		if (c_w == '0 || (c_w - cvs_pkg::ARITH_W'(1)) < floor_w) begin
			dn_w = floor_w;
		end else begin
			dn_w = c_w - cvs_pkg::ARITH_W'(1);
		end
	end

	// Clamp to what the counter holds
	assign nv_w  = match ? up_w : dn_w;
	assign sat_w = (nv_w > cvs_pkg::CNT_TOP) ? cvs_pkg::CNT_TOP : nv_w;
	assign nv    = sat_w[cvs_pkg::COUNTER_BITS-1:0];

	// Activity: set on a matched counter reaching the threshold, clear on an unmatched one below it
	always_comb begin
		res.new_val   = nv;
		res.active    = match ? (act | (sat_w >= thr_w)) : (act & (sat_w >= thr_w));
		res.take_best = !have || (nv > best_val);
	end

endmodule
`default_nettype wire

### src/class_vote_stabilizer_top.sv
// Class vote stabilizer: one result per decision; after a request is accepted the block walks
// n class counters (n is classes_in_use capped at MAX_CLASSES), then loads the result register.
// One item is in work at a time: a single update unit visits one class counter per cycle,
// and the result waits in an output register so the next request can enter meanwhile.
// Reset: counters clear to zero, activity clears, registers return to their defaults;
// no clearing pass is needed.
`default_nettype none
module class_vote_stabilizer_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [cvs_pkg::REG_W-1:0]   wr_index,
	input  wire logic [cvs_pkg::CFG_W-1:0]   wr_data,
	cvs_in_if.sink                           in_ch,
	cvs_out_if.source                        out_ch
);

	// Configuration registers
	logic [cvs_pkg::CIU_W-1:0] ciu_q;
	logic [cvs_pkg::CFG_W-1:0] floor_q;
	logic [cvs_pkg::CFG_W-1:0] ceil_q;
	logic [cvs_pkg::CFG_W-1:0] thr_q;

	// Walk state
	cvs_pkg::state_t state_q, state_d;
	logic [cvs_pkg::COUNTER_BITS-1:0] cnt_q [cvs_pkg::MAX_CLASSES];
	logic                             act_q;
	logic [cvs_pkg::WALK_W-1:0]       idx_q;
	logic [cvs_pkg::MEAS_W-1:0]       meas_q;
	logic                             have_q;
	logic [cvs_pkg::COUNTER_BITS-1:0] best_val_q;
	logic [cvs_pkg::IDX_W-1:0]        best_idx_q;

	// Output register
	logic                       out_valid_q;
	logic                       stable_valid_q;
	logic [cvs_pkg::SC_W-1:0]   stable_class_q;
	logic                       active_flag_q;

	logic [cvs_pkg::N_W-1:0]    n_eff;
	logic [cvs_pkg::IDX_W-1:0]  cur_idx;
	logic                       in_acc;
	logic                       last;
	logic                       match;
	logic                       in_ready;
	logic                       walk_en;
	logic                       fin_load;
	logic                       res_valid;
	cvs_pkg::step_res_t         step;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q   <= cvs_pkg::CIU_RST;
			floor_q <= cvs_pkg::FLOOR_RST;
			ceil_q  <= cvs_pkg::CEIL_RST;
			thr_q   <= cvs_pkg::THR_RST;
		end else if (wr_en) begin
			unique case (cvs_pkg::cfg_reg_t'(wr_index))
				cvs_pkg::REG_CLASSES_IN_USE: ciu_q   <= wr_data[cvs_pkg::CIU_W-1:0];
				cvs_pkg::REG_COUNT_FLOOR:    floor_q <= wr_data;
				cvs_pkg::REG_COUNT_CEILING:  ceil_q  <= wr_data;
				cvs_pkg::REG_VOTE_THRESHOLD: thr_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Cap the class count at the number of counters
	assign n_eff = (cvs_pkg::N_W'(ciu_q) > cvs_pkg::N_W'(cvs_pkg::MAX_CLASSES))
		? cvs_pkg::N_W'(cvs_pkg::MAX_CLASSES) : cvs_pkg::N_W'(ciu_q);

	assign cur_idx = idx_q[cvs_pkg::IDX_W-1:0];
	assign in_acc  = in_ch.valid && in_ready;
	assign last    = (cvs_pkg::N_W'(idx_q) + cvs_pkg::N_W'(1)) == n_eff;
	assign match   = cvs_pkg::CMP_W'(cur_idx) == cvs_pkg::CMP_W'(meas_q);

	cvs_update_unit u_update (
		.cnt       (cnt_q[cur_idx]),
		.match     (match),
		.floor_val (floor_q),
		.ceil_val  (ceil_q),
		.thr_val   (thr_q),
		.act       (act_q),
		.have      (have_q),
		.best_val  (best_val_q),
		.res       (step)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cvs_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = (n_eff == '0) ? cvs_pkg::ST_FINISH : cvs_pkg::ST_WALK;
				end
			end
			cvs_pkg::ST_WALK: begin
				if (last) begin
					state_d = cvs_pkg::ST_FINISH;
				end
			end
			cvs_pkg::ST_FINISH: begin
				if (fin_load) begin
					state_d = cvs_pkg::ST_IDLE;
				end
			end
			default: state_d = cvs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		walk_en  = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			cvs_pkg::ST_IDLE:   in_ready = 1'b1;
			cvs_pkg::ST_WALK:   walk_en  = 1'b1;
			cvs_pkg::ST_FINISH: fin_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cvs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the walk: update one counter, activity and the running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cvs_pkg::MAX_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
			act_q      <= 1'b0;
			idx_q      <= '0;
			have_q     <= 1'b0;
			meas_q     <= '0;
			best_val_q <= '0;
			best_idx_q <= '0;
		end else if (in_acc) begin
			meas_q <= in_ch.measured_class;
			idx_q  <= '0;
			have_q <= 1'b0;
		end else if (walk_en) begin
			cnt_q[cur_idx] <= step.new_val;
			act_q          <= step.active;
			idx_q          <= idx_q + cvs_pkg::WALK_W'(1);
			if (step.take_best) begin
				best_val_q <= step.new_val;
				best_idx_q <= cur_idx;
				have_q     <= 1'b1;
			end
		end
	end

	assign res_valid = have_q &&
		(cvs_pkg::ARITH_W'(best_val_q) > cvs_pkg::ARITH_W'(thr_q));

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			stable_valid_q <= res_valid;
			stable_class_q <= res_valid ? cvs_pkg::SC_W'(best_idx_q) : '0;
			active_flag_q  <= act_q;
		end
	end

	assign in_ch.ready         = in_ready;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.stable_valid = stable_valid_q;
	assign out_ch.stable_class = stable_class_q;
	assign out_ch.active_flag  = active_flag_q;

`ifndef SYNTH
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cvs_pkg::ST_WALK |-> cvs_pkg::N_W'(idx_q) < n_eff)
		else $error("walk index beyond classes in use");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != cvs_pkg::ST_IDLE)
		else $error("accepted request did not start work");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == cvs_pkg::ST_FINISH))
		else $error("result appeared outside finish step");

	a_best_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cvs_pkg::ST_FINISH && n_eff != '0 |-> have_q)
		else $error("walk finished without a strongest class");

	a_invalid_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !stable_valid_q |-> stable_class_q == '0)
		else $error("invalid result carries a class index");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking bench for class_vote_stabilizer_top. A mirror of the per-class
// vote counters predicts every result, and a clocked driver and monitor run the handshakes.
// Depends on cvs_pkg, cvs_in_if and cvs_out_if, and on the block itself.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCLS      = cvs_pkg::MAX_CLASSES;
	localparam int VOTE_TOP  = (1 << cvs_pkg::COUNTER_BITS) - 1;
	localparam int RUN_LIMIT = 500000;

	typedef struct packed {
		logic                        stable_valid;
		logic [cvs_pkg::SC_W-1:0]    stable_class;
		logic                        active_flag;
	} verdict_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        wr_en;
	logic [cvs_pkg::REG_W-1:0]   wr_index;
	logic [cvs_pkg::CFG_W-1:0]   wr_data;

	cvs_in_if  in_bus ();
	cvs_out_if out_bus ();

	class_vote_stabilizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (in_bus),
		.out_ch   (out_bus)
	);

	// Mirror of the block: counters, activity and register settings
	logic [cvs_pkg::COUNTER_BITS-1:0] votes [NCLS] = '{default: '0};
	logic                             activity = 1'b0;
	logic [cvs_pkg::CIU_W-1:0]        cfg_classes;
	logic [cvs_pkg::CFG_W-1:0]        cfg_floor;
	logic [cvs_pkg::CFG_W-1:0]        cfg_ceil;
	logic [cvs_pkg::CFG_W-1:0]        cfg_thr;

	logic [cvs_pkg::MEAS_W-1:0] decisions [$];
	verdict_t                   verdicts_due [$];

	int   errors = 0;
	int   accepted = 0;
	int   send_gap;
	int   sink_stall;
	int   cycles;
	logic calm;
	logic hold_off;

	always #5 clk = ~clk;

	task automatic report(string msg);
		$display("tb_top: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Walk the counters in use for one decision and return the expected result
	function automatic verdict_t advance_votes(logic [cvs_pkg::MEAS_W-1:0] meas);
		int n, c, nv, best_idx, best_val;
		verdict_t v;
		n = (cfg_classes > NCLS) ? NCLS : cfg_classes;
		for (int i = 0; i < n; i++) begin
			c = votes[i];
			if (i == meas) begin
				nv = c + 1;
				if (nv > cfg_ceil)
					nv = cfg_ceil;
				if (nv > VOTE_TOP)
					nv = VOTE_TOP;
				votes[i] = nv[cvs_pkg::COUNTER_BITS-1:0];
				if (nv >= cfg_thr && !activity)
					activity = 1'b1;
			end else begin
				if (c == 0 || c - 1 < cfg_floor)
					nv = cfg_floor;
				else
					nv = c - 1;
				if (nv > VOTE_TOP)
					nv = VOTE_TOP;
				votes[i] = nv[cvs_pkg::COUNTER_BITS-1:0];
				if (nv < cfg_thr && activity)
					activity = 1'b0;
			end
		end
		best_idx = 0;
		best_val = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || votes[i] > best_val) begin
				best_val = votes[i];
				best_idx = i;
			end
		end
		v = '0;
		if (n > 0 && best_val > cfg_thr) begin
			v.stable_valid = 1'b1;
			v.stable_class = best_idx[cvs_pkg::SC_W-1:0];
		end
		v.active_flag = activity;
		return v;
	endfunction

	// Write all four registers on consecutive edges, then release the port
	task automatic program_regs(logic [7:0] ciu, logic [7:0] fl, logic [7:0] ce,
			logic [7:0] th);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= cvs_pkg::REG_CLASSES_IN_USE;
		wr_data  <= ciu;
		cfg_classes = ciu[cvs_pkg::CIU_W-1:0];
		@(posedge clk);
		wr_index <= cvs_pkg::REG_COUNT_FLOOR;
		wr_data  <= fl;
		cfg_floor = fl;
		@(posedge clk);
		wr_index <= cvs_pkg::REG_COUNT_CEILING;
		wr_data  <= ce;
		cfg_ceil = ce;
		@(posedge clk);
		wr_index <= cvs_pkg::REG_VOTE_THRESHOLD;
		wr_data  <= th;
		cfg_thr = th;
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_run(int cls, int len);
		repeat (len) decisions.insert(decisions.size(), cls[cvs_pkg::MEAS_W-1:0]);
	endtask

	// Mostly runs of one in-range class, the rest single random decisions
	task automatic queue_random(int count);
		int left, len, cls, n, longest;
		n = (cfg_classes > NCLS) ? NCLS : cfg_classes;
		left = count;
		while (left > 0) begin
			if (n == 0 || $urandom_range(0, 3) == 0) begin
				decisions.insert(decisions.size(), cvs_pkg::MEAS_W'($urandom_range(0, 63)));
				left--;
			end else begin
				cls = $urandom_range(0, n - 1);
				longest = (cfg_ceil > 30 && $urandom_range(0, 3) == 0) ? 80 : 30;
				len = $urandom_range(1, longest);
				if (len > left)
					len = left;
				queue_run(cls, len);
				left -= len;
			end
		end
	endtask

	// Wait until every decision is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (decisions.size() != 0 || verdicts_due.size() != 0);
	endtask

	// Driver: offer queued decisions, hold each until taken, idle in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid          <= 1'b0;
			in_bus.measured_class <= '0;
			send_gap              <= 0;
		end else begin
			if (in_bus.valid && in_bus.ready) begin
				verdicts_due.insert(verdicts_due.size(),
					advance_votes(in_bus.measured_class));
				void'(decisions.pop_front());
				accepted++;
			end
			if (in_bus.valid && !in_bus.ready) begin
				// hold the pending request
			end else if (send_gap != 0) begin
				send_gap     <= send_gap - 1;
				in_bus.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap     <= $urandom_range(0, 14);
				in_bus.valid <= 1'b0;
			end else if (decisions.size() != 0) begin
				in_bus.valid          <= 1'b1;
				in_bus.measured_class <= decisions[0];
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each taken result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			sink_stall    <= 0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				if (verdicts_due.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					verdict_t want;
					want = verdicts_due.pop_front();
					if (out_bus.stable_valid !== want.stable_valid)
						report($sformatf("stable_valid got %b want %b",
							out_bus.stable_valid, want.stable_valid));
					if (out_bus.stable_class !== want.stable_class)
						report($sformatf("stable_class got %0d want %0d",
							out_bus.stable_class, want.stable_class));
					if (out_bus.active_flag !== want.active_flag)
						report($sformatf("active_flag got %b want %b",
							out_bus.active_flag, want.active_flag));
				end
			end
			if (hold_off) begin
				out_bus.ready <= 1'b0;
			end else if (sink_stall != 0) begin
				sink_stall    <= sink_stall - 1;
				out_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_stall    <= $urandom_range(0, 14);
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// Back-pressure: stop taking results for a long stretch so the input stalls
	initial begin
		hold_off = 1'b0;
		do
			@(negedge clk);
		while (accepted < 150);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b0;
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// Sequence: reset, directed checks, then random phases under varied settings
	initial begin
		logic [7:0] ciu, fl, ce, th;
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = cvs_pkg::REG_CLASSES_IN_USE;
		wr_data        = '0;
		calm           = 1'b0;
		cfg_classes = cvs_pkg::CIU_RST;
		cfg_floor   = cvs_pkg::FLOOR_RST;
		cfg_ceil    = cvs_pkg::CEIL_RST;
		cfg_thr     = cvs_pkg::THR_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults: rise past the threshold, then out-of-range and edge classes
		queue_run(0, 1);
		queue_run(5, 12);
		queue_run(63, 1);
		queue_run(16, 1);
		queue_run(15, 3);
		queue_run(0, 2);
		drain();

		// No classes in use: nothing moves, activity keeps its value
		program_regs(8'd0, 8'd255, 8'd255, 8'd0);
		queue_run(3, 1);
		queue_run(0, 1);
		drain();

		// Too many classes, floor above ceiling
		program_regs({3'b111, 5'd31}, 8'd200, 8'd50, 8'd100);
		queue_run(7, 2);
		queue_run(40, 1);
		drain();

		for (int phase = 0; phase < 14; phase++) begin
			case ($urandom_range(0, 9))
				0: begin
					ciu = 8'd16; fl = 8'd0; ce = 8'd255; th = 8'd0;
				end
				1: begin
					ciu = 8'd1; fl = 8'd255; ce = 8'd0; th = 8'd255;
				end
				2: begin
					ciu = 8'($urandom_range(17, 31)); fl = 8'd0; ce = 8'd30; th = 8'd5;
				end
				3: begin
					ciu = 8'd0; fl = 8'($urandom); ce = 8'($urandom); th = 8'($urandom);
				end
				4: begin
					ciu = 8'($urandom_range(1, 16)); fl = 8'd250; ce = 8'd255; th = 8'd252;
				end
				default: begin
					ciu = 8'($urandom_range(1, 16));
					fl  = 8'($urandom_range(0, 8));
					ce  = 8'(fl + $urandom_range(0, 40));
					th  = 8'($urandom_range(0, ce + 2));
				end
			endcase
			// upper data bits of the class count are don't-care; toggle them anyway
			ciu[7:5] = 3'($urandom);
			program_regs(ciu, fl, ce, th);
			if (phase == 13)
				calm = 1'b1;
			queue_random(84);
			drain();
		end

		repeat (24) @(posedge clk);
		if (verdicts_due.size() != 0)
			report($sformatf("%0d results never arrived", verdicts_due.size()));
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
